FILE: rtl/spdpg_pkg.sv
// Shared types, register indexes and constants of the step/direction pulse generator.
package spdpg_pkg;

  localparam int unsigned PositionBitsDefault = 32;
  localparam int unsigned FullStepW = 24;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned MaxShift = 8;

  localparam logic [CfgIndexW-1:0] RegMicrostepShift = 3'd0;
  localparam logic [CfgIndexW-1:0] RegStepPeriod     = 3'd1;
  localparam logic [CfgIndexW-1:0] RegStepHigh       = 3'd2;
  localparam logic [CfgIndexW-1:0] RegDirSettle      = 3'd3;
  localparam logic [CfgIndexW-1:0] RegProcOffset     = 3'd4;
  localparam logic [CfgIndexW-1:0] RegInvertDir      = 3'd5;

  localparam logic [1:0] FuncTick      = 2'd0;
  localparam logic [1:0] FuncSetTarget = 2'd1;
  localparam logic [1:0] FuncSetPos    = 2'd2;

  typedef struct packed {
    logic [3:0]  microstep_shift;
    logic [23:0] step_period_us;
    logic [15:0] step_high_us;
    logic [15:0] dir_settle_us;
    logic [15:0] processing_offset_us;
    logic        invert_direction;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] target_full_steps;
    logic signed [31:0] position_microsteps;
  } req_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic               at_target;
    logic               stepped;
    logic signed [23:0] position_full_steps;
    logic signed [23:0] target_steps_out;
  } rsp_t;

endpackage

FILE: rtl/spdpg_cfg_regs.sv
// Configuration register file of the step/direction pulse generator.
module spdpg_cfg_regs import spdpg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMicrostepShift: cfg_d.microstep_shift      = cfg_data_i[3:0];
        RegStepPeriod:     cfg_d.step_period_us       = cfg_data_i[23:0];
        RegStepHigh:       cfg_d.step_high_us         = cfg_data_i[15:0];
        RegDirSettle:      cfg_d.dir_settle_us        = cfg_data_i[15:0];
        RegProcOffset:     cfg_d.processing_offset_us = cfg_data_i[15:0];
        RegInvertDir:      cfg_d.invert_direction     = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.microstep_shift      <= 4'd0;
      cfg_q.step_period_us       <= 24'd3000;
      cfg_q.step_high_us         <= 16'd2;
      cfg_q.dir_settle_us        <= 16'd120;
      cfg_q.processing_offset_us <= 16'd0;
      cfg_q.invert_direction     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/spdpg_core.sv
// Position, target and pulse phase state with the per-request update logic.
module spdpg_core import spdpg_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_fire_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output rsp_t rsp_o
);

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [1:0] BaseSettle = 2'd1;
  localparam logic [1:0] BaseHigh   = 2'd2;

  logic signed [POSITION_BITS-1:0] pos_q, pos_d, tgt_q, tgt_d;
  logic        dir_q, dir_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] timer_q, timer_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic        at_tgt_q, at_tgt_d;
  logic        stepped_q, stepped_d;

  logic [3:0]  eff_shift;
  logic [15:0] high_m1;
  logic        fwd;
  logic        want_dir;
  logic        period_ok;
  logic        step_lvl;
  logic signed [POSITION_BITS-1:0] pos_bias, tgt_bias, pos_div, tgt_div;

  assign eff_shift = (cfg_i.microstep_shift > 4'(MaxShift)) ? 4'(MaxShift)
                                                             : cfg_i.microstep_shift;
  assign high_m1 = (cfg_i.step_high_us == 16'd0) ? 16'd0 : cfg_i.step_high_us - 16'd1;
  assign fwd = pos_q < tgt_q;
  assign want_dir = fwd ? cfg_i.invert_direction : ~cfg_i.invert_direction;

  always_comb begin
    pos_d     = pos_q;
    tgt_d     = tgt_q;
    dir_d     = dir_q;
    phase_d   = phase_q;
    timer_d   = timer_q;
    elapsed_d = elapsed_q;
    at_tgt_d  = at_tgt_q;
    stepped_d = stepped_q;
    period_ok = 1'b0;
    step_lvl  = 1'b0;
    unique case (req_i.func)
      FuncTick: begin
        if (phase_q == PhIdle) begin
          if (elapsed_q != 32'hFFFF_FFFF) begin
            elapsed_d = elapsed_q + 32'd1;
          end
          period_ok = ({1'b0, elapsed_d} + 33'(cfg_i.processing_offset_us))
                      >= 33'(cfg_i.step_period_us);
          if (pos_q == tgt_q) begin
            at_tgt_d = 1'b1;
          end else begin
            at_tgt_d = 1'b0;
            if (period_ok) begin
              dir_d = want_dir;
              if (dir_q != want_dir && cfg_i.dir_settle_us != 16'd0) begin
                phase_d = {~fwd, BaseSettle};
                timer_d = cfg_i.dir_settle_us - 16'd1;
              end else begin
                phase_d = {~fwd, BaseHigh};
                timer_d = high_m1;
              end
            end else begin
              stepped_d = 1'b0;
            end
          end
        end
        step_lvl = (phase_d[1:0] == BaseHigh);
        if (phase_d != PhIdle) begin
          if (timer_d != 16'd0) begin
            timer_d = timer_d - 16'd1;
          end else if (phase_d[1:0] == BaseSettle || phase_d[1:0] == BaseHigh) begin
            phase_d = {phase_d[2], phase_d[1:0] + 2'd1};
            timer_d = high_m1;
          end else begin
            pos_d     = phase_d[2] ? pos_q - POSITION_BITS'(1) : pos_q + POSITION_BITS'(1);
            stepped_d = 1'b1;
            elapsed_d = 32'd0;
            phase_d   = PhIdle;
            timer_d   = 16'd0;
          end
        end
      end
      FuncSetTarget: begin
        tgt_d = POSITION_BITS'(req_i.target_full_steps) << eff_shift;
        step_lvl = (phase_q[1:0] == BaseHigh);
      end
      FuncSetPos: begin
        pos_d = POSITION_BITS'(req_i.position_microsteps);
        step_lvl = (phase_q[1:0] == BaseHigh);
      end
      default: begin
        step_lvl = (phase_q[1:0] == BaseHigh);
      end
    endcase
  end

  // round toward zero: bias negative values before the arithmetic shift
  assign pos_bias = pos_d[POSITION_BITS-1]
                    ? POSITION_BITS'((9'd1 << eff_shift) - 9'd1) : '0;
  assign tgt_bias = tgt_d[POSITION_BITS-1]
                    ? POSITION_BITS'((9'd1 << eff_shift) - 9'd1) : '0;
  assign pos_div = (pos_d + pos_bias) >>> eff_shift;
  assign tgt_div = (tgt_d + tgt_bias) >>> eff_shift;

  always_comb begin
    rsp_o.step_level          = step_lvl;
    rsp_o.dir_level           = dir_d;
    rsp_o.at_target           = at_tgt_d;
    rsp_o.stepped             = stepped_d;
    rsp_o.position_full_steps = FullStepW'(pos_div);
    rsp_o.target_steps_out    = FullStepW'(tgt_div);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      tgt_q     <= '0;
      dir_q     <= 1'b0;
      phase_q   <= PhIdle;
      timer_q   <= 16'd0;
      elapsed_q <= 32'd0;
      at_tgt_q  <= 1'b0;
      stepped_q <= 1'b0;
    end else if (req_fire_i) begin
      pos_q     <= pos_d;
      tgt_q     <= tgt_d;
      dir_q     <= dir_d;
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      elapsed_q <= elapsed_d;
      at_tgt_q  <= at_tgt_d;
      stepped_q <= stepped_d;
    end
  end

endmodule

FILE: rtl/step_dir_position_pulse_generator.sv
// Step/direction stepper pulse generator top level with output register.
//
// Usage: each request on the in channel is a one-microsecond tick (func 0),
// a set-target command (func 1, target in full steps) or a set-position
// command (func 2, raw microsteps). Every request yields exactly one response
// on the out channel with the step and direction pin levels, the at-target
// and stepped flags, and position and target in full steps (toward zero).
// The cfg channel writes the six timing and scaling registers by index; it
// is always ready; the user must write it only while the block is idle, and
// the block itself does not enforce this. A request's response is registered
// and shows from the cycle after the request is accepted. Throughput: one
// request per cycle while the receiver takes responses, set by the single state
// update between the state registers and the output register. in_ready_o is
// high while the output register is empty or being drained, so a stalled
// receiver holds the response and stops intake after one request, without loss.
// Reset: position, target, direction, phase, timers and flags clear, the
// registers take their defaults (period 3000, high 2, settle 120) and the
// output register empties.
module step_dir_position_pulse_generator import spdpg_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t cfg;
  rsp_t rsp;
  rsp_t rsp_q;
  logic out_valid_q;
  logic fire;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign fire = in_valid_i & in_ready_o;

  spdpg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spdpg_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_fire_i (fire),
    .req_i      (in_req_i),
    .cfg_i      (cfg),
    .rsp_o      (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = rsp_q;

endmodule
